### rtl/core/qmm_pkg.sv
// ----------------------------------------------------------------------------
// qmm_pkg
// Shared types and constants for the quad motor mix and average pulse core.
// ----------------------------------------------------------------------------
package qmm_pkg;

	localparam int SUM_W    = 22;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int MUL_A_W  = 22;
	localparam int MUL_B_W  = 17;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int NUM_MOT  = 4;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam logic [2:0] REG_THROTTLE_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_THROTTLE_SCALE     = 3'd1;
	localparam logic [2:0] REG_MIN_PULSE          = 3'd2;
	localparam logic [2:0] REG_MAX_PULSE          = 3'd3;
	localparam logic [2:0] REG_UPDATE_THRESHOLD   = 3'd4;

	localparam logic [14:0] RST_THROTTLE_THRESHOLD = 15'd1638;
	localparam logic [14:0] RST_THROTTLE_SCALE     = 15'd16384;
	localparam logic [15:0] RST_MIN_PULSE          = 16'd1000;
	localparam logic [15:0] RST_MAX_PULSE          = 16'd2000;
	localparam logic [15:0] RST_UPDATE_THRESHOLD   = 16'd18000;

	typedef struct packed {
		logic [14:0] throttle_threshold;
		logic [14:0] throttle_scale;
		logic [15:0] min_pulse;
		logic [15:0] max_pulse;
		logic [15:0] update_threshold;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_MIX,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_MUL,
		ST_MAP,
		ST_EMIT
	} state_t;

endpackage

### rtl/core/qmm_intf.sv
// ----------------------------------------------------------------------------
// qmm_intf
// Valid/ready channels for the tick words and the pulse words.
// ----------------------------------------------------------------------------
interface qmm_tick_if;
	logic               valid;
	logic               ready;
	logic               motors_enabled;
	logic        [14:0] throttle;
	logic signed [15:0] ctrl_x;
	logic signed [15:0] ctrl_y;
	logic        [15:0] timer_count;

	modport source (
		output valid, motors_enabled, throttle, ctrl_x, ctrl_y, timer_count,
		input  ready
	);
	modport sink (
		input  valid, motors_enabled, throttle, ctrl_x, ctrl_y, timer_count,
		output ready
	);
endinterface

interface qmm_pulse_if;
	logic        valid;
	logic        ready;
	logic [15:0] pulse_motor_1;
	logic [15:0] pulse_motor_2;
	logic [15:0] pulse_motor_3;
	logic [15:0] pulse_motor_4;

	modport source (
		output valid, pulse_motor_1, pulse_motor_2, pulse_motor_3, pulse_motor_4,
		input  ready
	);
	modport sink (
		input  valid, pulse_motor_1, pulse_motor_2, pulse_motor_3, pulse_motor_4,
		output ready
	);
endinterface

### rtl/core/qmm_regs.sv
// ----------------------------------------------------------------------------
// qmm_regs
// APB register file holding thresholds, throttle gain and pulse range.
// ----------------------------------------------------------------------------
module qmm_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qmm_pkg::ADDR_W-1:0]   paddr,
	input  logic [qmm_pkg::DATA_W-1:0]   pwdata,
	output logic [qmm_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output qmm_pkg::cfg_t                cfg
);

	qmm_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.throttle_threshold <= qmm_pkg::RST_THROTTLE_THRESHOLD;
			cfg_q.throttle_scale     <= qmm_pkg::RST_THROTTLE_SCALE;
			cfg_q.min_pulse          <= qmm_pkg::RST_MIN_PULSE;
			cfg_q.max_pulse          <= qmm_pkg::RST_MAX_PULSE;
			cfg_q.update_threshold   <= qmm_pkg::RST_UPDATE_THRESHOLD;
		end else if (wr_en) begin
			unique case (idx)
				qmm_pkg::REG_THROTTLE_THRESHOLD: cfg_q.throttle_threshold <= pwdata[14:0];
				qmm_pkg::REG_THROTTLE_SCALE:     cfg_q.throttle_scale     <= pwdata[14:0];
				qmm_pkg::REG_MIN_PULSE:          cfg_q.min_pulse          <= pwdata[15:0];
				qmm_pkg::REG_MAX_PULSE:          cfg_q.max_pulse          <= pwdata[15:0];
				qmm_pkg::REG_UPDATE_THRESHOLD:   cfg_q.update_threshold   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			qmm_pkg::REG_THROTTLE_THRESHOLD: prdata = {17'd0, cfg_q.throttle_threshold};
			qmm_pkg::REG_THROTTLE_SCALE:     prdata = {17'd0, cfg_q.throttle_scale};
			qmm_pkg::REG_MIN_PULSE:          prdata = {16'd0, cfg_q.min_pulse};
			qmm_pkg::REG_MAX_PULSE:          prdata = {16'd0, cfg_q.max_pulse};
			qmm_pkg::REG_UPDATE_THRESHOLD:   prdata = {16'd0, cfg_q.update_threshold};
			default:                         prdata = '0;
		endcase
	end

endmodule

### rtl/core/qmm_divider.sv
// ----------------------------------------------------------------------------
// qmm_divider
// Radix-2 restoring divider, signed sum by unsigned count, one bit a cycle.
// ----------------------------------------------------------------------------
module qmm_divider #(
	parameter int CNT_W = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [qmm_pkg::SUM_W-1:0]  dividend,
	input  logic        [CNT_W-1:0]           divisor,
	output logic                              busy,
	output logic                              done,
	output logic signed [qmm_pkg::SUM_W-1:0]  quotient
);

	localparam int SUM_W  = qmm_pkg::SUM_W;
	localparam int STEP_W = $clog2(SUM_W + 1);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    div_q;
	logic [SUM_W-1:0]    mag_q;
	logic                neg_q;
	logic                zero_q;
	logic [CNT_W:0]      trial;
	logic                fits;
	logic [CNT_W:0]      diff;

	assign trial = {rem_q, mag_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			div_q  <= divisor;
			neg_q  <= dividend[SUM_W-1];
			zero_q <= (divisor == '0);
			mag_q  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			mag_q <= {mag_q[SUM_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = zero_q ? '0 : (neg_q ? -$signed(mag_q) : $signed(mag_q));

endmodule

### rtl/core/quad_motor_mix_average_pulse_core.sv
// ----------------------------------------------------------------------------
// quad_motor_mix_average_pulse_core
// Plus-configuration quad motor mixer that averages samples per PWM period.
// ----------------------------------------------------------------------------
// A tick word that causes no pulse word passes through the idle, base and mix
// states. When the timer count reaches the update threshold the four averages
// are worked out one motor at a time on a shared serial divider and a shared
// multiplier, each motor passing through the divide, multiply and map states,
// before the pulse word is offered. The tick channel is not ready
// while a word is being worked on; a finished pulse word waits in the output
// register without holding up the next tick word.
module quad_motor_mix_average_pulse_core #(
	parameter int MAX_SAMPLES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	qmm_tick_if.sink                     tick,
	qmm_pulse_if.source                  pulse,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qmm_pkg::ADDR_W-1:0]   paddr,
	input  logic [qmm_pkg::DATA_W-1:0]   pwdata,
	output logic [qmm_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = qmm_pkg::SUM_W;
	localparam int PROD_W = qmm_pkg::PROD_W;
	localparam int NM     = qmm_pkg::NUM_MOT;

	qmm_pkg::cfg_t   cfg;
	qmm_pkg::state_t state_q;
	qmm_pkg::state_t state_d;

	logic                              en_q;
	logic [14:0]                       thr_q;
	logic signed [15:0]                cx_q;
	logic signed [15:0]                cy_q;
	logic [15:0]                       timer_q;

	logic signed [SUM_W-1:0]           sum_q [NM];
	logic signed [SUM_W-1:0]           sum_d [NM];
	logic [CNT_W-1:0]                  cnt_q;
	logic [CNT_W-1:0]                  cnt_d;
	logic [1:0]                        ch_q;
	logic [15:0]                       res_q [NM];
	logic [15:0]                       pulse_q [NM];
	logic                              out_valid_q;

	logic signed [qmm_pkg::MUL_A_W-1:0] mul_a_q;
	logic signed [qmm_pkg::MUL_B_W-1:0] mul_b_q;
	logic signed [PROD_W-1:0]           prod_s1;

	logic                              div_start;
	logic                              div_busy;
	logic                              div_done;
	logic signed [SUM_W-1:0]           div_quot;

	logic [15:0]                       base;
	logic signed [17:0]                term [NM];
	logic signed [22:0]                acc  [NM];
	logic                              active;
	logic                              do_update;
	logic                              emit_go;
	logic signed [16:0]                span;
	logic signed [39:0]                pv;
	logic [15:0]                       pmap;

	qmm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qmm_divider #(
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[ch_q]),
		.divisor  (cnt_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a_q * mul_b_q;
	end

	// mix update
	assign base      = prod_s1[29:14];
	assign active    = en_q && (thr_q > cfg.throttle_threshold);
	assign do_update = timer_q >= cfg.update_threshold;

	always_comb begin
		logic signed [17:0] b18;
		logic signed [17:0] x18;
		logic signed [17:0] y18;
		b18 = $signed({2'b00, base});
		x18 = 18'(cx_q);
		y18 = 18'(cy_q);
		term[0] = b18 - y18;
		term[1] = b18 + x18;
		term[2] = b18 + y18;
		term[3] = b18 - x18;
		for (int i = 0; i < NM; i++) begin
			acc[i] = 23'(sum_q[i]) + 23'(term[i]);
		end
		for (int i = 0; i < NM; i++) begin
			sum_d[i] = sum_q[i];
		end
		cnt_d = cnt_q;
		if (!en_q) begin
			for (int i = 0; i < NM; i++) sum_d[i] = '0;
			cnt_d = CNT_W'(1);
		end else if (!active) begin
			for (int i = 0; i < NM; i++) sum_d[i] = $signed({7'd0, thr_q});
			cnt_d = CNT_W'(1);
		end else if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
			for (int i = 0; i < NM; i++) begin
				if (acc[i][22] != acc[i][21]) begin
					sum_d[i] = acc[i][22] ? qmm_pkg::SUM_MIN : qmm_pkg::SUM_MAX;
				end else begin
					sum_d[i] = acc[i][21:0];
				end
			end
			cnt_d = cnt_q + 1'b1;
		end
	end

	// pulse mapping
	assign span = $signed({1'b0, cfg.max_pulse}) - $signed({1'b0, cfg.min_pulse});
	assign pv   = $signed({10'd0, cfg.min_pulse, 14'd0}) + 40'(prod_s1);

	always_comb begin
		if (pv[39]) begin
			pmap = '0;
		end else if (|pv[38:30]) begin
			pmap = 16'hFFFF;
		end else begin
			pmap = pv[29:14];
		end
	end

	assign emit_go = (state_q == qmm_pkg::ST_EMIT) && (!out_valid_q || pulse.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qmm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		tick.ready = 1'b0;
		unique case (state_q)
			qmm_pkg::ST_IDLE: begin
				tick.ready = 1'b1;
				if (tick.valid) state_d = qmm_pkg::ST_BASE;
			end
			qmm_pkg::ST_BASE: begin
				state_d = qmm_pkg::ST_MIX;
			end
			qmm_pkg::ST_MIX: begin
				state_d = do_update ? qmm_pkg::ST_DIV_START : qmm_pkg::ST_IDLE;
			end
			qmm_pkg::ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = qmm_pkg::ST_DIV_WAIT;
			end
			qmm_pkg::ST_DIV_WAIT: begin
				if (div_done) state_d = qmm_pkg::ST_MUL;
			end
			qmm_pkg::ST_MUL: begin
				state_d = qmm_pkg::ST_MAP;
			end
			qmm_pkg::ST_MAP: begin
				state_d = (ch_q == 2'(NM - 1)) ? qmm_pkg::ST_EMIT : qmm_pkg::ST_DIV_START;
			end
			qmm_pkg::ST_EMIT: begin
				if (emit_go) state_d = qmm_pkg::ST_IDLE;
			end
			default: state_d = qmm_pkg::ST_IDLE;
		endcase
	end

	// accumulator state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NM; i++) sum_q[i] <= '0;
			cnt_q       <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (pulse.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				qmm_pkg::ST_MIX: begin
					for (int i = 0; i < NM; i++) sum_q[i] <= sum_d[i];
					cnt_q <= cnt_d;
					ch_q  <= '0;
				end
				qmm_pkg::ST_MAP: begin
					ch_q <= ch_q + 1'b1;
				end
				qmm_pkg::ST_EMIT: begin
					if (emit_go) begin
						for (int i = 0; i < NM; i++) sum_q[i] <= '0;
						cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			qmm_pkg::ST_IDLE: begin
				if (tick.valid) begin
					en_q    <= tick.motors_enabled;
					thr_q   <= tick.throttle;
					cx_q    <= tick.ctrl_x;
					cy_q    <= tick.ctrl_y;
					timer_q <= tick.timer_count;
					mul_a_q <= $signed({7'd0, tick.throttle});
					mul_b_q <= $signed({2'b00, cfg.throttle_scale});
				end
			end
			qmm_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					mul_a_q <= div_quot;
					mul_b_q <= span;
				end
			end
			qmm_pkg::ST_MAP: begin
				res_q[ch_q] <= pmap;
			end
			qmm_pkg::ST_EMIT: begin
				if (emit_go) begin
					for (int i = 0; i < NM; i++) pulse_q[i] <= res_q[i];
				end
			end
			default: ;
		endcase
	end

	assign pulse.valid         = out_valid_q;
	assign pulse.pulse_motor_1 = pulse_q[0];
	assign pulse.pulse_motor_2 = pulse_q[1];
	assign pulse.pulse_motor_3 = pulse_q[2];
	assign pulse.pulse_motor_4 = pulse_q[3];

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count above limit");

	a_div_launch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == qmm_pkg::ST_DIV_START |=> div_busy)
		else $error("divider did not start");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == qmm_pkg::ST_DIV_START |-> cnt_q != '0)
		else $error("division by zero count");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> pulse.valid && state_q == qmm_pkg::ST_IDLE && cnt_q == '0)
		else $error("pulse word not presented after emit");
`endif

endmodule
